// File: rtl/core/assert_macros.svh
// Assertion helpers used by the datapath RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

// File: rtl/core/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    // Field widths fixed by the stream format
    localparam int REQ_TYPE_W   = 2;
    localparam int SLOT_IDX_W   = 4;
    localparam int SIZE_VALUE_W = 16;
    localparam int TAG_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 8;
    localparam int FIT_MODE_W   = 2;
    localparam int BLK_COUNT_W  = 5;

    // Request kinds (code 3 is a no-op without a result)
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_FIT    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_CLEARED   = 2'd3;

    // Fit policies (code 3 behaves as first fit)
    localparam logic [FIT_MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [FIT_MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [FIT_MODE_W-1:0] MODE_WORST = 2'd2;

    // Register indexes on the config channel
    localparam logic [CFG_INDEX_W-1:0] CFG_FIT_MODE    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } fpa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;        // capture the accepted item
        logic write_size;   // load a slot size
        logic clear_taken;  // free every slot
        logic scan;         // step the slot scan
        logic commit;       // mark the winner taken, form the result
        logic load_out;     // move the result into the output register
    } fpa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;    // all used slots read and evaluated
        logic out_free;     // output register can take a result
    } fpa_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/fit_policy_partition_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Fixed-partition allocator with first, best and worst fit. A load item writes one slot size,
// an allocate item claims the chosen free slot whose size covers the request (ties go to the
// lowest slot), a clear item frees every slot; each gives one result. A load or clear goes
// from acceptance straight to the result register; an allocate first scans the used slots, where
// used is block_count clamped to NUM_SLOTS, because the slot sizes sit in a single-port memory
// that a counter reads one slot per cycle, then compares the last slot read and commits the
// taken mark. The result register lets the next item be accepted while a result waits. Config
// writes are taken only between items; no clearing pass is needed after reset, and a slot must
// be loaded before an allocate can look at it.
module fit_policy_partition_allocator #(
    parameter int NUM_SLOTS = 16,
    parameter int SIZE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // slot_index[3:0], size_value[19:4], request_tag[27:20]
    input  wire logic [7:0]  s_tuser,   // req_type[1:0]
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // granted_slot[3:0], tag_echo[11:4]
    output logic [7:0]       m_tuser,   // status[1:0]
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [fpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fpa_pkg::*;

    fpa_cmd_t              cmd;
    fpa_sts_t              sts;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [STATUS_W-1:0]   m_status;
    logic [SLOT_IDX_W-1:0] m_slot;
    logic [TAG_W-1:0]      m_tag;

    assign req_type = s_tuser[REQ_TYPE_W-1:0];

    fpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req_type  (req_type),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fpa_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .slot_index  (s_tdata[3:0]),
        .size_value  (s_tdata[19:4]),
        .request_tag (s_tdata[27:20]),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_status    (m_status),
        .m_slot      (m_slot),
        .m_tag       (m_tag)
    );

    // Result packing
    assign m_tdata = {4'b0000, m_tag, m_slot};
    assign m_tuser = {6'b000000, m_status};

endmodule

`default_nettype wire

// File: rtl/core/fpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fpa_ctrl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [fpa_pkg::REQ_TYPE_W-1:0]   req_type,
    output logic                                  cfg_ready,
    input  wire fpa_pkg::fpa_sts_t                sts,
    output fpa_pkg::fpa_cmd_t                     cmd
);
    import fpa_pkg::*;

    fpa_state_t state_reg;
    fpa_state_t state_next;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req_type == REQ_ALLOC) begin
                        state_next = ST_SCAN;
                    end else if (req_type == REQ_LOAD || req_type == REQ_CLEAR) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // no transfers while reset is held
                s_tready        = aresetn;
                cfg_ready       = aresetn;
                cmd.latch       = accept && (req_type == REQ_LOAD || req_type == REQ_ALLOC
                                             || req_type == REQ_CLEAR);
                cmd.write_size  = accept && (req_type == REQ_LOAD);
                cmd.clear_taken = accept && (req_type == REQ_CLEAR);
            end
            ST_SCAN: begin
                cmd.scan   = 1'b1;
                cmd.commit = sts.scan_done;
            end
            ST_DONE: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/fpa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fpa_datapath #(
    parameter int NUM_SLOTS = 16,
    parameter int SIZE_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire fpa_pkg::fpa_cmd_t                   cmd,
    output fpa_pkg::fpa_sts_t                        sts,
    input  wire logic [fpa_pkg::REQ_TYPE_W-1:0]      req_type,
    input  wire logic [fpa_pkg::SLOT_IDX_W-1:0]      slot_index,
    input  wire logic [fpa_pkg::SIZE_VALUE_W-1:0]    size_value,
    input  wire logic [fpa_pkg::TAG_W-1:0]           request_tag,
    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic [fpa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [fpa_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [fpa_pkg::STATUS_W-1:0]             m_status,
    output logic [fpa_pkg::SLOT_IDX_W-1:0]           m_slot,
    output logic [fpa_pkg::TAG_W-1:0]                m_tag
);
    import fpa_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = (CNT_W > BLK_COUNT_W) ? CNT_W : BLK_COUNT_W;
    localparam int EXT_W = 48;

    // Slot sizes, written by loads, read once per scan step
    logic [SIZE_BITS-1:0] size_mem [NUM_SLOTS];
    logic [SIZE_BITS-1:0] rd_data_reg;

    logic [NUM_SLOTS-1:0]  taken_reg;
    logic [FIT_MODE_W-1:0] fit_mode_reg;
    logic [BLK_COUNT_W-1:0] block_count_reg;

    logic [SIZE_BITS-1:0] req_size_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [CNT_W-1:0]     scan_idx_reg;
    logic                 eval_vld_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0] pick_size_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [IDX_W-1:0]     res_slot_reg;

    logic                 m_tvalid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [SLOT_IDX_W-1:0] m_slot_reg;
    logic [TAG_W-1:0]     m_tag_reg;

    logic [SIZE_BITS-1:0] in_size;
    logic [EXT_W-1:0]     in_size_ext;
    logic [7:0]           load_idx_ext;
    logic                 load_in_range;
    logic [IDX_W-1:0]     load_addr;
    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     used_ext;
    logic [CNT_W-1:0]     used;
    logic                 issue;
    logic                 candidate;
    logic                 better;
    logic [7:0]           res_slot_ext;

    // Input size kept in SIZE_BITS bits
    assign in_size_ext = EXT_W'(size_value);
    assign in_size     = in_size_ext[SIZE_BITS-1:0];

    // Load address and range check
    assign load_idx_ext  = 8'(slot_index);
    assign load_in_range = load_idx_ext < 8'(NUM_SLOTS);
    assign load_addr     = load_idx_ext[IDX_W-1:0];

    // Slots in use, count clamped to the table depth
    assign count_ext = CMP_W'(block_count_reg);
    assign used_ext  = (count_ext > CMP_W'(NUM_SLOTS)) ? CMP_W'(NUM_SLOTS) : count_ext;
    assign used      = used_ext[CNT_W-1:0];

    assign issue = cmd.scan && (scan_idx_reg != used);

    // Evaluate the slot read in the previous cycle
    assign candidate = eval_vld_reg && !taken_reg[eval_idx_reg] && (rd_data_reg >= req_size_reg);
    assign better    = !found_reg
                     || (fit_mode_reg == MODE_BEST  && rd_data_reg < pick_size_reg)
                     || (fit_mode_reg == MODE_WORST && rd_data_reg > pick_size_reg);

    assign sts.scan_done = (scan_idx_reg == used) && !eval_vld_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Size memory
    always_ff @(posedge aclk) begin
        if (cmd.write_size && load_in_range) begin
            size_mem[load_addr] <= in_size;
        end
        if (issue) begin
            rd_data_reg <= size_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // Config registers, taken marks, scan control, output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg    <= MODE_FIRST;
            block_count_reg <= '0;
            taken_reg       <= '0;
            eval_vld_reg    <= 1'b0;
            found_reg       <= 1'b0;
            scan_idx_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                priority if (cfg_index == CFG_FIT_MODE) begin
                    fit_mode_reg <= cfg_data[FIT_MODE_W-1:0];
                end else if (cfg_index == CFG_BLOCK_COUNT) begin
                    block_count_reg <= cfg_data[BLK_COUNT_W-1:0];
                end
            end

            if (cmd.latch) begin
                scan_idx_reg <= '0;
                eval_vld_reg <= 1'b0;
                found_reg    <= 1'b0;
            end

            if (cmd.clear_taken) begin
                taken_reg <= '0;
            end

            if (cmd.scan) begin
                eval_vld_reg <= issue;
                if (issue) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (candidate && better) begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.commit) begin
                found_reg <= 1'b0;
                if (found_reg) begin
                    taken_reg[pick_reg] <= 1'b1;
                end
            end

            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            req_size_reg   <= in_size;
            tag_reg        <= request_tag;
            res_slot_reg   <= '0;
            res_status_reg <= (req_type == REQ_LOAD) ? STAT_LOADED : STAT_CLEARED;
        end
        if (cmd.scan) begin
            eval_idx_reg <= scan_idx_reg[IDX_W-1:0];
            if (candidate && better) begin
                pick_reg      <= eval_idx_reg;
                pick_size_reg <= rd_data_reg;
            end
        end
        if (cmd.commit) begin
            res_status_reg <= found_reg ? STAT_ALLOCATED : STAT_NO_FIT;
            res_slot_reg   <= found_reg ? pick_reg : '0;
        end
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_ext[SLOT_IDX_W-1:0];
            m_tag_reg    <= tag_reg;
        end
    end

    assign res_slot_ext = 8'(res_slot_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;
    assign m_tag    = m_tag_reg;

    // A committed winner is marked taken on the next edge
    `ASSERT_CLK(a_commit_marks, aclk, aresetn, (cmd.commit && found_reg) |=> taken_reg[$past(pick_reg)])
    // Only a grant carries a nonzero slot number
    `ASSERT_NEVER(a_slot_only_on_grant, aclk, aresetn, m_tvalid_reg && (m_status_reg != STAT_ALLOCATED) && (m_slot_reg != '0))
    // A pending winner always lies inside the slots in use
    `ASSERT_NEVER(a_pick_in_range, aclk, aresetn, found_reg && (CNT_W'(pick_reg) >= used))

endmodule

`default_nettype wire
